/* rtl/lcfc_pkg.sv */
// ----------------------------------------------------------------------------
// LED channel frame chaser package
// Shared types, constants and the channel send order for the frame chaser.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfc_pkg;

  localparam int unsigned Channels    = 12;
  localparam int unsigned FrameWords  = Channels + 1;
  localparam int unsigned ChanW       = $clog2(Channels);
  localparam int unsigned CntW        = $clog2(FrameWords);
  localparam logic [15:0] CmdWord     = 16'h0410;
  localparam logic [31:0] ChaseStepMs = 32'd500;
  localparam logic [31:0] ChaseIdleMs = 32'd2000;
  localparam logic [7:0]  BrightReset = 8'd15;

  typedef enum logic [1:0] {
    ReqShow  = 2'd0,
    ReqMulti = 2'd1,
    ReqTick  = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [3:0]          key_index;
    logic [Channels-1:0] light_mask;
    logic [31:0]         now_ms;
  } in_t;

  typedef struct packed {
    logic [15:0] frame_word;
    logic        is_command;
    logic        latch_after;
  } out_t;

  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctrl_t;

  // Channel held by each ring position, in the order the driver expects.
  function automatic logic [ChanW-1:0] send_chan(input logic [ChanW-1:0] pos);
    logic [ChanW-1:0] chan;
    case (pos)
      4'd0:    chan = 4'd2;
      4'd1:    chan = 4'd1;
      4'd2:    chan = 4'd0;
      4'd3:    chan = 4'd5;
      4'd4:    chan = 4'd4;
      4'd5:    chan = 4'd3;
      default: chan = pos;
    endcase
    return chan;
  endfunction

endpackage

`default_nettype wire

/* rtl/led_channel_frame_chaser.sv */
// ----------------------------------------------------------------------------
// LED channel frame chaser
// Twelve-channel LED level store with a running-light chase, emitting
// thirteen-word driver frames.
// ----------------------------------------------------------------------------
// A request is taken only while no frame is being sent. A show, multi or
// chase-step tick is accepted and then sent as thirteen output beats; a
// tick that produces no frame leaves the block idle and ready. Each frame
// is read from the ring of twelve channel cells, which rotates by one
// position per data beat so that the head cell always holds the next word's
// level. After the twelfth rotation the ring is back in its original order,
// so the levels survive the frame unchanged. Brightness is written through
// its own port, which is always ready; it should only be written while idle.
`default_nettype none

module led_channel_frame_chaser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lcfc_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lcfc_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [7:0]     cfg_data_i
);

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

  localparam logic [lcfc_pkg::CntW-1:0] LastWord =
    lcfc_pkg::CntW'(lcfc_pkg::FrameWords - 1);
  localparam logic [lcfc_pkg::ChanW-1:0] LastChan =
    lcfc_pkg::ChanW'(lcfc_pkg::Channels - 1);
  localparam logic [lcfc_pkg::ChanW-1:0] NumChan =
    lcfc_pkg::ChanW'(lcfc_pkg::Channels);

  state_e                        state_q, state_d;
  logic [lcfc_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [lcfc_pkg::ChanW-1:0]    pos_q, pos_d;
  logic [31:0]                   deadline_q, deadline_d;
  logic                          chase_on_q, chase_on_d;
  logic [7:0]                    bright_q, bright_d;

  logic                          in_fire;
  logic                          out_fire;
  logic [lcfc_pkg::Channels-1:0] lit;
  lcfc_pkg::cell_ctrl_t          cell_ctrl;
  logic [7:0]                    ring_level [lcfc_pkg::Channels];

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StEmit);
  assign out_fire    = out_valid_o && out_ready_i;
  assign cfg_ready_o = 1'b1;

  // Request decode and chase bookkeeping. Every frame-producing request
  // reloads all cells at once from the lit vector, indexed by channel.
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    pos_d            = pos_q;
    deadline_d       = deadline_q;
    chase_on_d       = chase_on_q;
    bright_d         = bright_q;
    lit              = '0;
    cell_ctrl.load   = 1'b0;
    cell_ctrl.rotate = 1'b0;

    if (cfg_valid_i) begin
      bright_d = cfg_data_i;
    end

    if (in_fire) begin
      unique case (in_data_i.req_type)
        lcfc_pkg::ReqShow: begin
          chase_on_d = 1'b0;
          if (in_data_i.key_index < NumChan) begin
            lit = lcfc_pkg::Channels'(1) << in_data_i.key_index;
          end
          cell_ctrl.load = 1'b1;
        end
        lcfc_pkg::ReqMulti: begin
          chase_on_d     = 1'b0;
          lit            = in_data_i.light_mask;
          cell_ctrl.load = 1'b1;
        end
        lcfc_pkg::ReqTick: begin
          if (chase_on_q && (deadline_q < in_data_i.now_ms)) begin
            // Chase step: light the current position and move on.
            deadline_d = in_data_i.now_ms + lcfc_pkg::ChaseStepMs;
            if (pos_q < NumChan) begin
              lit = lcfc_pkg::Channels'(1) << pos_q;
            end
            // The position wraps after the last channel, and an out-of-range
            // position restarts at zero.
            pos_d          = (pos_q >= LastChan) ? '0 : pos_q + 1'b1;
            cell_ctrl.load = 1'b1;
          end else if ((deadline_q + lcfc_pkg::ChaseIdleMs) < in_data_i.now_ms) begin
            // Quiet for long enough: start the chase with the next tick.
            chase_on_d = 1'b1;
          end
        end
        default: begin
          // Unused request code: nothing changes.
        end
      endcase
      if (cell_ctrl.load) begin
        state_d = StEmit;
        cnt_d   = '0;
      end
    end

    // Each data beat rotates the ring so the next channel reaches the head.
    if (out_fire) begin
      cell_ctrl.rotate = (cnt_q != '0);
      if (cnt_q == LastWord) begin
        state_d = StIdle;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      pos_q      <= '0;
      deadline_q <= '0;
      chase_on_q <= 1'b0;
      bright_q   <= lcfc_pkg::BrightReset;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      deadline_q <= deadline_d;
      chase_on_q <= chase_on_d;
      bright_q   <= bright_d;
    end
  end

  // Ring of channel cells in send order: position zero is the head, and each
  // cell takes its successor's level when the ring rotates.
  for (genvar g = 0; g < lcfc_pkg::Channels; g++) begin : g_cell
    localparam int unsigned Next = (g + 1) % lcfc_pkg::Channels;
    logic [lcfc_pkg::ChanW-1:0] chan;
    logic [7:0]                 load_level;

    assign chan       = lcfc_pkg::send_chan(lcfc_pkg::ChanW'(g));
    assign load_level = lit[chan] ? bright_q : 8'h00;

    lcfc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .load_level_i (load_level),
      .next_level_i (ring_level[Next]),
      .level_o      (ring_level[g])
    );
  end

  // The first beat of a frame is the command word; the rest come from the
  // head cell, and the latch mark rides on the final beat.
  always_comb begin
    out_data_o.is_command  = (cnt_q == '0);
    out_data_o.latch_after = (cnt_q == LastWord);
    out_data_o.frame_word  = out_data_o.is_command ? lcfc_pkg::CmdWord
                                                   : {8'h00, ring_level[0]};
  end

endmodule

`default_nettype wire

/* rtl/lcfc_cell.sv */
// ----------------------------------------------------------------------------
// LED channel cell
// Holds one channel level; loads a new level or takes its neighbour's level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfc_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lcfc_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]          load_level_i,
  input  wire logic [7:0]          next_level_i,
  output logic [7:0]               level_o
);

  logic [7:0] level_q, level_d;

  always_comb begin
    level_d = level_q;
    if (ctrl_i.load) begin
      level_d = load_level_i;
    end else if (ctrl_i.rotate) begin
      level_d = next_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 8'h00;
    end else begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

`default_nettype wire

/* bench/led_channel_frame_chaser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED channel frame chaser testbench
// Sends show, multi and tick requests through the request channel under
// random idling on both sides. A scoreboard keeps its own copy of the channel
// levels and the chase state, builds the thirteen-word frame that each request
// should cause, and checks every output beat against it field by field.
// ----------------------------------------------------------------------------

module led_channel_frame_chaser_tb;

  // The package names the three real request kinds. The fourth code is unused
  // and the block is meant to drop it without any effect.
  localparam logic [1:0] ReqUnused = 2'd3;

  // Cycles allowed after the last frame word before the block counts as idle.
  // A tick that moves no frame still has to be taken in by the block.
  localparam int unsigned SettleCycles = 20;

  // --------------------------------------------------------------------------
  // Scoreboard: a predictor of the channel store and chase state, plus the
  // queue of frame words still owed by the block.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [7:0]      level [lcfc_pkg::Channels];
    logic [3:0]      position;
    logic [31:0]     deadline;
    bit              chase_on;
    logic [7:0]      brightness;
    lcfc_pkg::out_t  frame_q[$];
    int unsigned     errors;
    int unsigned     frames_seen;
    int unsigned     words_seen;

    function new();
      foreach (level[i]) level[i] = 8'h00;
      position    = '0;
      deadline    = '0;
      chase_on    = 1'b0;
      brightness  = lcfc_pkg::BrightReset;
      errors      = 0;
      frames_seen = 0;
      words_seen  = 0;
    endfunction

    function void set_brightness(logic [7:0] value);
      brightness = value;
    endfunction

    function int unsigned pending();
      return frame_q.size();
    endfunction

    // The command word, then the twelve levels. The first two groups of three
    // channels go out reversed within the group; the rest go out in order.
    function void push_frame();
      lcfc_pkg::out_t w;
      int unsigned    chan;
      w.frame_word  = lcfc_pkg::CmdWord;
      w.is_command  = 1'b1;
      w.latch_after = 1'b0;
      frame_q.push_back(w);
      for (int unsigned i = 0; i < lcfc_pkg::Channels; i++) begin
        chan = (i < 6) ? (i / 3) * 3 + 2 - (i % 3) : i;
        w.frame_word  = {8'h00, level[chan]};
        w.is_command  = 1'b0;
        w.latch_after = (i == lcfc_pkg::Channels - 1);
        frame_q.push_back(w);
      end
    endfunction

    function void note_input(lcfc_pkg::in_t req);
      case (req.req_type)
        lcfc_pkg::ReqShow: begin
          chase_on = 1'b0;
          foreach (level[i]) level[i] = 8'h00;
          if (req.key_index < lcfc_pkg::Channels) level[req.key_index] = brightness;
          push_frame();
        end
        lcfc_pkg::ReqMulti: begin
          chase_on = 1'b0;
          foreach (level[i]) level[i] = req.light_mask[i] ? brightness : 8'h00;
          push_frame();
        end
        lcfc_pkg::ReqTick: begin
          // Both comparisons are unsigned on 32 bits, with the sums wrapping.
          if (chase_on && deadline < req.now_ms) begin
            deadline = req.now_ms + lcfc_pkg::ChaseStepMs;
            foreach (level[i]) level[i] = 8'h00;
            if (position < lcfc_pkg::Channels) level[position] = brightness;
            if (position >= 4'(lcfc_pkg::Channels - 1)) position = '0;
            else position = position + 4'd1;
            push_frame();
          end else if (deadline + lcfc_pkg::ChaseIdleMs < req.now_ms) begin
            chase_on = 1'b1;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(lcfc_pkg::out_t got);
      lcfc_pkg::out_t want;
      if (frame_q.size() == 0) begin
        errors++;
        $display("%0t: word %h arrived with no frame outstanding", $time, got.frame_word);
        return;
      end
      want = frame_q.pop_front();
      words_seen++;
      if (want.is_command) frames_seen++;
      if (got.frame_word !== want.frame_word) begin
        errors++;
        $display("%0t: frame_word expected %h, got %h", $time, want.frame_word,
                 got.frame_word);
      end
      if (got.is_command !== want.is_command) begin
        errors++;
        $display("%0t: is_command expected %b, got %b", $time, want.is_command,
                 got.is_command);
      end
      if (got.latch_after !== want.latch_after) begin
        errors++;
        $display("%0t: latch_after expected %b, got %b", $time, want.latch_after,
                 got.latch_after);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts at a known value.
  // --------------------------------------------------------------------------
  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  lcfc_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  lcfc_pkg::out_t out_data_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [7:0]     cfg_data_i  = 8'h00;

  frame_scoreboard sb = new();

  // Running millisecond time of the well-formed tick stream.
  logic [31:0] cur_ms;
  // When set, that side of the link runs without idle cycles.
  bit          tx_free;
  bit          rx_free;
  int unsigned n_requests;
  int unsigned n_ignored;

  led_channel_frame_chaser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs. The slowest correct run, with every
  // word stalled to the limit and every request gapped to the limit, stays
  // well under a millisecond, so this leaves a wide margin.
  initial begin
    #5_000_000;
    $display("Timeout waiting for the block to finish");
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side. Before each beat the consumer holds ready low for a random
  // number of cycles, unless it is in a free-running stretch. Ready stays high
  // until the beat has been taken, so no word is ever lost between draws.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_free ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(out_data_o);
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------
  function automatic lcfc_pkg::in_t make_req(logic [1:0] kind, logic [3:0] key,
                                             logic [11:0] mask, logic [31:0] now);
    lcfc_pkg::in_t r;
    r.req_type   = kind;
    r.key_index  = key;
    r.light_mask = mask;
    r.now_ms     = now;
    return r;
  endfunction

  // Valid is only lowered when a gap is drawn, so back-to-back beats keep it
  // high with a single assignment per time step. The beat is handed to the
  // scoreboard at the edge where the handshake completes.
  task automatic send_request(input lcfc_pkg::in_t req);
    int unsigned gap;
    gap = tx_free ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_input(req);
    if (req.req_type == ReqUnused) n_ignored++;
    else n_requests++;
  endtask

  // Holds the sender back until every owed word has come, then lets the block
  // finish any frameless tick it may still be working on.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_brightness(input logic [7:0] value);
    drain_and_settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sb.set_brightness(value);
  endtask

  // Mostly a tick stream whose time moves forward in steps around the chase
  // period, now and then jumping far enough for the chase to restart. Shows
  // and multis break the chase, random times and the unused code act as
  // noise. A random tick time also becomes the new base of the stream, which
  // brings it across the 32-bit wrap from time to time.
  function automatic lcfc_pkg::in_t random_req();
    lcfc_pkg::in_t r;
    int unsigned   pick;
    r.key_index  = 4'($urandom_range(0, 15));
    r.light_mask = 12'($urandom_range(0, 4095));
    r.now_ms     = $urandom;
    pick         = $urandom_range(0, 99);
    if (pick < 9) begin
      r.req_type = lcfc_pkg::ReqShow;
    end else if (pick < 18) begin
      r.req_type = lcfc_pkg::ReqMulti;
    end else if (pick < 22) begin
      r.req_type = ReqUnused;
    end else if (pick < 27) begin
      r.req_type = lcfc_pkg::ReqTick;
      cur_ms     = r.now_ms;
    end else begin
      r.req_type = lcfc_pkg::ReqTick;
      if ($urandom_range(0, 9) == 0) cur_ms = cur_ms + $urandom_range(2600, 4000);
      else cur_ms = cur_ms + $urandom_range(0, 700);
      r.now_ms = cur_ms;
    end
    return r;
  endfunction

  task automatic run_random(input int unsigned count);
    lcfc_pkg::in_t req;
    int unsigned   done;
    done = 0;
    while (done < count) begin
      // Every so often, change whether each side idles, so that there are
      // long stretches at full rate as well as heavily gapped ones.
      if (done % 25 == 0) begin
        tx_free = ($urandom_range(0, 2) == 0);
        rx_free = ($urandom_range(0, 2) == 0);
      end
      req = random_req();
      send_request(req);
      if (req.req_type != ReqUnused) done++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned wait_cycles;
    cur_ms     = '0;
    tx_free    = 1'b0;
    rx_free    = 1'b0;
    n_requests = 0;
    n_ignored  = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset brightness. Single keys at both ends of the
    // range and beyond it, full, empty and mixed masks, and the unused code.
    send_request(make_req(lcfc_pkg::ReqShow, 4'd0, 12'h000, 32'h0));
    send_request(make_req(lcfc_pkg::ReqShow, 4'd11, 12'hFFF, 32'hFFFF_FFFF));
    send_request(make_req(lcfc_pkg::ReqShow, 4'd12, 12'h000, 32'h0));
    send_request(make_req(lcfc_pkg::ReqShow, 4'd15, 12'hFFF, 32'h0));
    send_request(make_req(lcfc_pkg::ReqMulti, 4'd0, 12'hFFF, 32'h0));
    send_request(make_req(lcfc_pkg::ReqMulti, 4'd15, 12'hA5A, 32'h0));
    send_request(make_req(lcfc_pkg::ReqMulti, 4'd3, 12'h000, 32'hFFFF_FFFF));
    send_request(make_req(ReqUnused, 4'd5, 12'hFFF, 32'hFFFF_FFFF));
    // With the deadline at zero, a tick at zero does nothing, one just past
    // the idle time turns the chase on, and the next one lights channel 0.
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'd0));
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'd2001));
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'd2002));
    // A tick exactly at the deadline must not step the chase.
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'd2502));
    // Twelve steps take the running light all the way round and past the wrap.
    for (int unsigned k = 1; k <= 12; k++) begin
      send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'(2002 + k * 501)));
    end
    cur_ms = 32'(2002 + 12 * 501);

    // Full brightness, and the deadline arithmetic across the 32-bit wrap.
    // The first tick sets a deadline just below the top, so the idle sum
    // wraps once the show has stopped the chase; the later ticks carry the
    // deadline itself over the wrap.
    write_brightness(8'hFF);
    tx_free = 1'b1;
    rx_free = 1'b1;
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'hFFFF_FE00));
    send_request(make_req(lcfc_pkg::ReqShow, 4'd3, 12'h000, 32'h0));
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'h0000_0010));
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'h0000_07C4));
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'h0000_07C5));
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'hFFFF_FFF5));
    send_request(make_req(lcfc_pkg::ReqTick, 4'd0, 12'h000, 32'h0000_01EA));
    cur_ms = 32'h0000_01EA;
    run_random(100);

    // Zero brightness: every frame carries blank levels.
    write_brightness(8'h00);
    run_random(60);

    // A random mid-range level for the longest random stretch.
    write_brightness(8'($urandom_range(1, 254)));
    run_random(140);

    // Let every owed word come back, then a little longer in case the block
    // sends anything it should not.
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t: %0d frame words never arrived", $time, sb.pending());
    end

    $display("Covered %0d requests plus %0d with the unused code, at four brightness levels.",
             n_requests, n_ignored);
    $display("Checked %0d frames, %0d words in all.", sb.frames_seen, sb.words_seen);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
